@@ sv/ptcp_pkg.sv @@
// ----------------------------------------------------------------------------
// ptcp_pkg
// Shared types and constants of the pan-tilt command parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ptcp_pkg;

  localparam int unsigned OffsetWidth   = 11;
  localparam int unsigned DurationWidth = 14;
  localparam int unsigned PulseWidth    = 12;
  localparam int unsigned StatusWidth   = 2;
  localparam int unsigned CharWidth     = 8;
  localparam int unsigned AngleWidth    = 8;
  localparam int unsigned RegIdxWidth   = 2;

  localparam logic [AngleWidth-1:0] ANGLE_MAX = 8'd180;

  localparam logic [OffsetWidth-1:0]   H_OFFSET_RESET = 11'd600;
  localparam logic [OffsetWidth-1:0]   V_OFFSET_RESET = 11'd700;
  localparam logic [DurationWidth-1:0] DURATION_RESET = 14'd100;

  localparam logic [RegIdxWidth-1:0] REG_H_OFFSET = 2'd0;
  localparam logic [RegIdxWidth-1:0] REG_V_OFFSET = 2'd1;
  localparam logic [RegIdxWidth-1:0] REG_DURATION = 2'd2;

  localparam logic [StatusWidth-1:0] ST_HORIZ     = 2'd0;
  localparam logic [StatusWidth-1:0] ST_VERT      = 2'd1;
  localparam logic [StatusWidth-1:0] ST_BOTH      = 2'd2;
  localparam logic [StatusWidth-1:0] ST_MALFORMED = 2'd3;

  localparam logic [1:0] HMARK_NONE  = 2'd0;
  localparam logic [1:0] HMARK_OPEN  = 2'd1;
  localparam logic [1:0] HMARK_AFTER = 2'd2;

  localparam logic [CharWidth-1:0] CHAR_TERM    = 8'h00;
  localparam logic [CharWidth-1:0] CHAR_L_LOWER = 8'h6C;
  localparam logic [CharWidth-1:0] CHAR_L_UPPER = 8'h4C;
  localparam logic [CharWidth-1:0] CHAR_V_LOWER = 8'h76;
  localparam logic [CharWidth-1:0] CHAR_V_UPPER = 8'h56;
  localparam logic [CharWidth-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CharWidth-1:0] CHAR_NINE    = 8'h39;

  typedef struct packed {
    logic [OffsetWidth-1:0]   h_offset;
    logic [OffsetWidth-1:0]   v_offset;
    logic [DurationWidth-1:0] duration;
  } ptcp_cfg_t;

  // scale an angle by ten and add the offset to form a pulse value
  function automatic logic [PulseWidth-1:0] pulse_of(
    input logic [AngleWidth-1:0]  angle,
    input logic [OffsetWidth-1:0] offset
  );
    logic [PulseWidth-1:0] scaled;
    scaled   = ({4'd0, angle} << 3) + ({4'd0, angle} << 1);
    pulse_of = scaled + {1'b0, offset};
  endfunction

endpackage

`default_nettype wire

@@ sv/ptcp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ptcp_cfg_regs
// APB register file: horizontal offset, vertical offset, move duration.
// ----------------------------------------------------------------------------
`default_nettype none

module ptcp_cfg_regs (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [3:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready,
  output ptcp_pkg::ptcp_cfg_t       cfg_o
);
  import ptcp_pkg::*;

  ptcp_cfg_t cfg_q, cfg_d;
  logic [RegIdxWidth-1:0] idx;
  logic wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_H_OFFSET: cfg_d.h_offset = pwdata[OffsetWidth-1:0];
        REG_V_OFFSET: cfg_d.v_offset = pwdata[OffsetWidth-1:0];
        REG_DURATION: cfg_d.duration = pwdata[DurationWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_H_OFFSET: prdata = {{(32-OffsetWidth){1'b0}}, cfg_q.h_offset};
      REG_V_OFFSET: prdata = {{(32-OffsetWidth){1'b0}}, cfg_q.v_offset};
      REG_DURATION: prdata = {{(32-DurationWidth){1'b0}}, cfg_q.duration};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.h_offset <= H_OFFSET_RESET;
      cfg_q.v_offset <= V_OFFSET_RESET;
      cfg_q.duration <= DURATION_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/ptcp_parser.sv @@
// ----------------------------------------------------------------------------
// ptcp_parser
// Character register, command state, and result register with handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module ptcp_parser #(
  parameter int unsigned NUMBER_WIDTH = 10
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire ptcp_pkg::ptcp_cfg_t                   cfg_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [ptcp_pkg::CharWidth-1:0]        in_char_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic      [ptcp_pkg::StatusWidth-1:0]      out_status_o,
  output logic      [ptcp_pkg::PulseWidth-1:0]       out_h_pulse_o,
  output logic      [ptcp_pkg::PulseWidth-1:0]       out_v_pulse_o,
  output logic      [ptcp_pkg::DurationWidth-1:0]    out_time_o
);
  import ptcp_pkg::*;

  localparam int unsigned AccWidth = NUMBER_WIDTH + 5;
  localparam logic [NUMBER_WIDTH-1:0] NumMax = {NUMBER_WIDTH{1'b1}};

  function automatic logic [NUMBER_WIDTH-1:0] accumulate(
    input logic [NUMBER_WIDTH-1:0] acc,
    input logic [3:0]              digit
  );
    logic [AccWidth-1:0] wide;
    wide = ({5'd0, acc} << 3) + ({5'd0, acc} << 1) + AccWidth'(digit);
    accumulate = (wide > AccWidth'(NumMax)) ? NumMax : wide[NUMBER_WIDTH-1:0];
  endfunction

  function automatic logic [AngleWidth-1:0] clamp(input logic [NUMBER_WIDTH-1:0] n);
    clamp = (n > NUMBER_WIDTH'(ANGLE_MAX)) ? ANGLE_MAX : n[AngleWidth-1:0];
  endfunction

  logic                  chr_valid_q;
  logic [CharWidth-1:0]  chr_q;
  logic                  stage_ready;

  logic [1:0]              hmark_q, hmark_d;
  logic                    vmark_q, vmark_d;
  logic [NUMBER_WIDTH-1:0] hnum_q, hnum_d;
  logic [NUMBER_WIDTH-1:0] vnum_q, vnum_d;

  logic                     res_valid_q;
  logic [StatusWidth-1:0]   res_status_q, res_status_d;
  logic [PulseWidth-1:0]    res_h_q, res_h_d;
  logic [PulseWidth-1:0]    res_v_q, res_v_d;
  logic [DurationWidth-1:0] res_t_q, res_t_d;

  logic is_term, is_l, is_v, is_digit, advance;

  assign stage_ready = !res_valid_q || out_ready_i;
  assign in_ready_o  = !chr_valid_q || stage_ready;
  assign advance     = chr_valid_q && stage_ready;

  assign is_term  = (chr_q == CHAR_TERM);
  assign is_l     = (chr_q == CHAR_L_LOWER) || (chr_q == CHAR_L_UPPER);
  assign is_v     = (chr_q == CHAR_V_LOWER) || (chr_q == CHAR_V_UPPER);
  assign is_digit = (chr_q >= CHAR_ZERO) && (chr_q <= CHAR_NINE);

  always_comb begin
    hmark_d = hmark_q;
    vmark_d = vmark_q;
    hnum_d  = hnum_q;
    vnum_d  = vnum_q;
    if (is_term) begin
      hmark_d = HMARK_NONE;
      vmark_d = 1'b0;
      hnum_d  = '0;
      vnum_d  = '0;
    end else if (is_l && hmark_q == HMARK_NONE) begin
      hmark_d = vmark_q ? HMARK_AFTER : HMARK_OPEN;
    end else if (is_v && !vmark_q) begin
      vmark_d = 1'b1;
    end else if (is_digit) begin
      if (vmark_q) begin
        vnum_d = accumulate(vnum_q, chr_q[3:0]);
      end else if (hmark_q != HMARK_NONE) begin
        hnum_d = accumulate(hnum_q, chr_q[3:0]);
      end
    end
  end

  always_comb begin
    res_status_d = ST_MALFORMED;
    res_h_d      = '0;
    res_v_d      = '0;
    res_t_d      = '0;
    priority if (hmark_q == HMARK_OPEN && !vmark_q) begin
      res_status_d = ST_HORIZ;
      res_h_d      = pulse_of(clamp(hnum_q), cfg_i.h_offset);
      res_t_d      = cfg_i.duration;
    end else if (hmark_q == HMARK_NONE && vmark_q) begin
      res_status_d = ST_VERT;
      res_v_d      = pulse_of(clamp(vnum_q), cfg_i.v_offset);
      res_t_d      = cfg_i.duration;
    end else if (hmark_q == HMARK_OPEN && vmark_q) begin
      res_status_d = ST_BOTH;
      res_h_d      = pulse_of(clamp(hnum_q), cfg_i.h_offset);
      res_v_d      = pulse_of(clamp(vnum_q), cfg_i.v_offset);
      res_t_d      = cfg_i.duration;
    end else begin
      res_status_d = ST_MALFORMED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chr_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      hmark_q     <= HMARK_NONE;
      vmark_q     <= 1'b0;
      hnum_q      <= '0;
      vnum_q      <= '0;
    end else begin
      if (in_ready_o) begin
        chr_valid_q <= in_valid_i;
      end
      if (advance) begin
        hmark_q <= hmark_d;
        vmark_q <= vmark_d;
        hnum_q  <= hnum_d;
        vnum_q  <= vnum_d;
      end
      if (stage_ready) begin
        res_valid_q <= advance && is_term;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      chr_q <= in_char_i;
    end
    if (advance && is_term) begin
      res_status_q <= res_status_d;
      res_h_q      <= res_h_d;
      res_v_q      <= res_v_d;
      res_t_q      <= res_t_d;
    end
  end

  assign out_valid_o   = res_valid_q;
  assign out_status_o  = res_status_q;
  assign out_h_pulse_o = res_h_q;
  assign out_v_pulse_o = res_v_q;
  assign out_time_o    = res_t_q;

endmodule

`default_nettype wire

@@ sv/pan_tilt_command_parser_top.sv @@
// ----------------------------------------------------------------------------
// pan_tilt_command_parser_top
// Parses pan-tilt command text into servo pulse values.
// ----------------------------------------------------------------------------
// Takes one ASCII character per beat on the slave stream; a zero byte ends a
// command and yields one result beat on the master stream after it passes the
// character register and then the result register. Any other character yields
// no result. One character is taken every cycle; the pace is set by the single
// character-register to result-register pass, and stalls only when the result
// register is held. Offsets and move duration are set over APB and should be
// written while no command result is pending.
`default_nettype none

module pan_tilt_command_parser_top #(
  parameter int unsigned NUMBER_WIDTH = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] character
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [39:0] m_axis_tdata_o,   // [11:0] horizontal_pulse,
                                             // [23:12] vertical_pulse,
                                             // [37:24] move_time, [39:38] zero
  output logic      [1:0]  m_axis_tuser_o    // [1:0] status
);
  import ptcp_pkg::*;

  ptcp_cfg_t                cfg;
  logic [PulseWidth-1:0]    h_pulse, v_pulse;
  logic [DurationWidth-1:0] move_time;

  ptcp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ptcp_parser #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_char_i     (s_axis_tdata_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_status_o  (m_axis_tuser_o),
    .out_h_pulse_o (h_pulse),
    .out_v_pulse_o (v_pulse),
    .out_time_o    (move_time)
  );

  assign m_axis_tdata_o = {2'b00, move_time, v_pulse, h_pulse};

endmodule

`default_nettype wire
